### hw/rtl/lbps_pkg.sv
// ----------------------------------------------------------------------------
// lbps_pkg: shared types and constants for the LED blink pattern sequencer
// Mode codes, config register indexes, reset values and state/result structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lbps_pkg;

	localparam int LED_COUNT = 3;
	localparam int LED_W     = 3;
	localparam int MODE_W    = 3;
	localparam int STEP_W    = 2;
	localparam int MS_W      = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [LED_W-1:0] LED_MASK =
		(LED_COUNT >= LED_W) ? {LED_W{1'b1}} : LED_W'((1 << LED_COUNT) - 1);

	// mode codes
	localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ON     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_BLINK  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FAST   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SLOW   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_BREATH = 3'd5;

	// word kinds on tuser
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_CMD  = 1'b1;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_STEP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_ON    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_OFF   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_ON    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_OFF   = 3'd4;

	localparam logic [MS_W-1:0] RST_BLINK_STEP = 16'd300;
	localparam logic [MS_W-1:0] RST_FAST_ON    = 16'd100;
	localparam logic [MS_W-1:0] RST_FAST_OFF   = 16'd200;
	localparam logic [MS_W-1:0] RST_SLOW_ON    = 16'd600;
	localparam logic [MS_W-1:0] RST_SLOW_OFF   = 16'd800;

	typedef struct packed {
		logic [MS_W-1:0] blink_step_ms;
		logic [MS_W-1:0] fast_on_ms;
		logic [MS_W-1:0] fast_off_ms;
		logic [MS_W-1:0] slow_on_ms;
		logic [MS_W-1:0] slow_off_ms;
	} cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [LED_W-1:0]  sel;
		logic [STEP_W-1:0] step;
		logic [MS_W-1:0]   elapsed;
	} state_t;

	typedef struct packed {
		logic [STEP_W-1:0] pattern_step;
		logic [LED_W-1:0]  led_drive;
	} result_t;

	// Number of steps in the pattern of a mode/mask pair.
	function automatic logic [STEP_W-1:0] steps_in_pattern(
		input logic [MODE_W-1:0] mode,
		input logic [LED_W-1:0]  sel
	);
		logic [STEP_W-1:0] cnt;
		logic [STEP_W-1:0] n;
		cnt = '0;
		for (int i = 0; i < LED_W; i++) begin
			cnt = cnt + STEP_W'(sel[i]);
		end
		if (mode == MODE_BLINK) begin
			if (cnt == 2'd0) begin
				n = 2'd1;
			end else if (cnt == 2'd1) begin
				n = 2'd2;
			end else begin
				n = cnt;
			end
		end else if (mode == MODE_FAST || mode == MODE_SLOW) begin
			n = 2'd2;
		end else begin
			n = 2'd1;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/led_blink_pattern_sequencer_top.sv
// ----------------------------------------------------------------------------
// led_blink_pattern_sequencer_top: LED blink pattern sequencer
// Steps a small LED bank through off/on/blink/flash patterns on ms ticks.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  --------  ---  -----------------  ------------------------------------------
//  s_        in   s_tvalid/s_tready  tuser: kind; tdata: mode, led_select
//  m_        out  m_tvalid/m_tready  tdata: led_drive, pattern_step
//  cfg_      in   cfg_we             cfg_index, cfg_data (no read-back)
//
//  One word per cycle while s_tready is high. The pattern state updates in the
//  cycle a word is accepted; its result sits in the output register the next cycle.
//  s_tready is high whenever the output register is empty or being drained,
//  so a stall on m_tready stalls the input by exactly one register.
//  Reset (arst_n low) loads the default durations, mode "on" with all LEDs,
//  step 0 and a cleared timer; the output register comes up empty.
//
`default_nettype none

module led_blink_pattern_sequencer_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// input stream
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [7:0]                         s_tdata,  // [2:0] mode, [5:3] led_select
	input  wire logic                               s_tuser,  // [0] kind: 0 tick, 1 command
	// result stream
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [7:0]                              m_tdata,  // [2:0] led_drive, [4:3] pattern_step
	// config write port
	input  wire logic                               cfg_we,
	input  wire logic [lbps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [lbps_pkg::MS_W-1:0]          cfg_data
);

	lbps_pkg::cfg_t    cfg_q;
	lbps_pkg::state_t  state_q;
	lbps_pkg::state_t  state_nxt;
	lbps_pkg::result_t res_nxt;
	lbps_pkg::result_t res_q;
	logic              m_valid_q;
	logic              s_acc;

	assign s_tready = !m_valid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;

	// duration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blink_step_ms <= lbps_pkg::RST_BLINK_STEP;
			cfg_q.fast_on_ms    <= lbps_pkg::RST_FAST_ON;
			cfg_q.fast_off_ms   <= lbps_pkg::RST_FAST_OFF;
			cfg_q.slow_on_ms    <= lbps_pkg::RST_SLOW_ON;
			cfg_q.slow_off_ms   <= lbps_pkg::RST_SLOW_OFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lbps_pkg::REG_BLINK_STEP: cfg_q.blink_step_ms <= cfg_data;
				lbps_pkg::REG_FAST_ON:    cfg_q.fast_on_ms    <= cfg_data;
				lbps_pkg::REG_FAST_OFF:   cfg_q.fast_off_ms   <= cfg_data;
				lbps_pkg::REG_SLOW_ON:    cfg_q.slow_on_ms    <= cfg_data;
				lbps_pkg::REG_SLOW_OFF:   cfg_q.slow_off_ms   <= cfg_data;
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	lbps_step u_step (
		.cfg        (cfg_q),
		.cur        (state_q),
		.kind       (s_tuser),
		.mode       (s_tdata[2:0]),
		.led_select (s_tdata[5:3]),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	// pattern state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode    <= lbps_pkg::MODE_ON;
			state_q.sel     <= lbps_pkg::LED_MASK;
			state_q.step    <= '0;
			state_q.elapsed <= '0;
		end else if (s_acc) begin
			state_q <= state_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_tready) begin
			m_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, res_q.pattern_step, res_q.led_drive};

`ifndef ASSERT_OFF
	// every accepted word yields a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> m_tvalid)
		else $error("accepted word produced no result");

	// breath and undefined codes never reach the stored mode
	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode <= lbps_pkg::MODE_SLOW)
		else $error("stored mode out of range");

	// held patterns always sit on step 0
	a_held_step0: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.mode == lbps_pkg::MODE_OFF || state_q.mode == lbps_pkg::MODE_ON)
		|-> state_q.step == '0)
		else $error("held pattern off step 0");

	// a command restarts the step timer
	a_cmd_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_tuser == lbps_pkg::KIND_CMD) |=> state_q.elapsed == '0)
		else $error("command did not clear elapsed time");
`endif

endmodule

`default_nettype wire

### hw/rtl/lbps_step.sv
// ----------------------------------------------------------------------------
// lbps_step: next-state and LED level logic
// One tick or mode command against the current state; purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module lbps_step (
	input  wire lbps_pkg::cfg_t                    cfg,
	input  wire lbps_pkg::state_t                  cur,
	input  wire logic                              kind,
	input  wire logic [lbps_pkg::MODE_W-1:0]       mode,
	input  wire logic [lbps_pkg::LED_W-1:0]        led_select,
	output lbps_pkg::state_t                       nxt,
	output lbps_pkg::result_t                      res
);

	always_comb begin
		logic [lbps_pkg::STEP_W-1:0] cnt;
		logic [lbps_pkg::STEP_W-1:0] idx;
		logic [lbps_pkg::STEP_W-1:0] adv;
		logic [lbps_pkg::MS_W-1:0]   dur;
		logic [lbps_pkg::MS_W-1:0]   inc;
		logic                        held;
		logic [lbps_pkg::STEP_W-1:0] k;
		logic [lbps_pkg::LED_W-1:0]  lvl;

		nxt  = cur;
		cnt  = '0;
		idx  = '0;
		adv  = '0;
		dur  = '0;
		held = 1'b1;
		inc  = cur.elapsed + 16'd1;

		if (kind == lbps_pkg::KIND_CMD) begin
			// undefined modes keep the pattern and only restart the timer
			if (mode <= lbps_pkg::MODE_BREATH) begin
				nxt.mode = (mode == lbps_pkg::MODE_BREATH) ? lbps_pkg::MODE_SLOW : mode;
				nxt.sel  = led_select & lbps_pkg::LED_MASK;
			end
			cnt = lbps_pkg::steps_in_pattern(nxt.mode, nxt.sel);
			if (cur.step >= cnt) begin
				nxt.step = '0;
			end
			nxt.elapsed = '0;
		end else begin
			cnt = lbps_pkg::steps_in_pattern(cur.mode, cur.sel);
			idx = (cur.step >= cnt) ? '0 : cur.step;
			unique case (cur.mode)
				lbps_pkg::MODE_BLINK: begin
					held = (cur.sel == '0);
					dur  = cfg.blink_step_ms;
				end
				lbps_pkg::MODE_FAST: begin
					held = 1'b0;
					dur  = (idx == '0) ? cfg.fast_on_ms : cfg.fast_off_ms;
				end
				lbps_pkg::MODE_SLOW: begin
					held = 1'b0;
					dur  = (idx == '0) ? cfg.slow_on_ms : cfg.slow_off_ms;
				end
				default: begin
					held = 1'b1;
				end
			endcase
			// a zero duration counts as one millisecond
			if (dur == '0) begin
				dur = 16'd1;
			end
			adv = idx + 2'd1;
			nxt.step = idx;
			if (!held) begin
				if (inc >= dur) begin
					nxt.elapsed = '0;
					nxt.step    = (adv >= cnt) ? '0 : adv;
				end else begin
					nxt.elapsed = inc;
				end
			end
		end

		// LED level of the step after this word
		lvl = '0;
		k   = '0;
		unique case (nxt.mode)
			lbps_pkg::MODE_ON: begin
				lvl = nxt.sel;
			end
			lbps_pkg::MODE_FAST, lbps_pkg::MODE_SLOW: begin
				lvl = (nxt.step == '0) ? nxt.sel : '0;
			end
			lbps_pkg::MODE_BLINK: begin
				// light the selected LED whose rank among set bits is the step
				for (int i = 0; i < lbps_pkg::LED_W; i++) begin
					if (nxt.sel[i]) begin
						if (k == nxt.step) begin
							lvl[i] = 1'b1;
						end
						k = k + 2'd1;
					end
				end
			end
			default: begin
				lvl = '0;
			end
		endcase

		res.led_drive    = lvl;
		res.pattern_step = nxt.step;
	end

endmodule

`default_nettype wire

### dv/led_blink_pattern_sequencer_top_test.sv
// ----------------------------------------------------------------------------
// led_blink_pattern_sequencer_top_test: self-checking bench for the sequencer
// Streams ticks and mode commands, predicts every LED word in a local model
// of the pattern state and compares each output word as it drains.
// ----------------------------------------------------------------------------

module led_blink_pattern_sequencer_top_test;

	import lbps_pkg::*;

	localparam int REG_COUNT = 5;                     // registers that exist
	localparam int IDX_TOP   = (1 << CFG_IDX_W) - 1;  // highest decodable index

	// command codes with no pattern behind them
	localparam logic [MODE_W-1:0] MODE_RSVD_A = 3'd6;
	localparam logic [MODE_W-1:0] MODE_RSVD_B = 3'd7;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;   // [2:0] mode, [5:3] led_select
	logic                 s_tuser;   // [0] kind
	logic                 m_tvalid;
	logic                 m_tready;
	logic [7:0]           m_tdata;   // [2:0] led_drive, [4:3] pattern_step
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [MS_W-1:0]      cfg_data;

	led_blink_pattern_sequencer_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// ------------------------------------------------------------------
	// Local copy of the pattern state and the duration registers
	// ------------------------------------------------------------------
	logic [MS_W-1:0]   duration_reg [REG_COUNT];
	logic [MODE_W-1:0] cur_mode;
	logic [LED_W-1:0]  cur_sel;
	int                cur_step;
	int                cur_elapsed;

	result_t           expected_leds [$];   // LED words still owed by the block
	int                mismatch_count;

	// traffic shaping, shared between the stimulus and the sink
	bit                tx_burst;   // sender offers back to back
	bit                rx_burst;   // sink never idles
	int                rx_hold;    // long sink stall, counted down by the sink

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run ceiling: far above the slowest legal run.
	initial begin : watchdog
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Number of steps in a pattern. Blink walks the lit LEDs; a single LED
	// gets an extra dark step, an empty mask is one dark step.
	function automatic int pattern_len(input logic [MODE_W-1:0] mode,
			input logic [LED_W-1:0] sel);
		int lit;
		lit = 0;
		for (int i = 0; i < LED_W; i++) begin
			lit += sel[i];
		end
		if (mode == MODE_BLINK) begin
			return (lit == 0) ? 1 : (lit == 1) ? 2 : lit;
		end
		if (mode == MODE_FAST || mode == MODE_SLOW) begin
			return 2;
		end
		return 1;
	endfunction

	// LED levels of the step now shown.
	function automatic logic [LED_W-1:0] lit_pattern();
		int k;
		k = 0;
		case (cur_mode)
			MODE_ON: return cur_sel;
			MODE_FAST, MODE_SLOW: return (cur_step == 0) ? cur_sel : 3'b000;
			MODE_BLINK: begin
				for (int i = 0; i < LED_W; i++) begin
					if (cur_sel[i]) begin
						if (k == cur_step) return LED_W'(1 << i);
						k++;
					end
				end
				return 3'b000;
			end
			default: return 3'b000;
		endcase
	endfunction

	// Length of the current step in ms; 0 means it is held forever.
	// A register left at zero counts as one millisecond.
	function automatic int step_span();
		int t;
		case (cur_mode)
			MODE_BLINK: begin
				if (cur_sel == 3'b000) return 0;
				t = duration_reg[REG_BLINK_STEP];
			end
			MODE_FAST: t = (cur_step == 0) ? duration_reg[REG_FAST_ON]
				: duration_reg[REG_FAST_OFF];
			MODE_SLOW: t = (cur_step == 0) ? duration_reg[REG_SLOW_ON]
				: duration_reg[REG_SLOW_OFF];
			default: return 0;
		endcase
		return (t == 0) ? 1 : t;
	endfunction

	// Apply one accepted word to the local state and queue the LED word.
	task automatic advance_pattern(input logic kind, input logic [MODE_W-1:0] mode,
			input logic [LED_W-1:0] sel);
		int      span;
		result_t r;
		if (kind == KIND_CMD) begin
			// undefined codes keep the pattern, breath runs as slow flash
			if (mode <= MODE_BREATH) begin
				cur_mode = (mode == MODE_BREATH) ? MODE_SLOW : mode;
				cur_sel  = sel & LED_MASK;
			end
			if (cur_step >= pattern_len(cur_mode, cur_sel)) cur_step = 0;
			cur_elapsed = 0;
		end else begin
			if (cur_step >= pattern_len(cur_mode, cur_sel)) cur_step = 0;
			span = step_span();
			if (span != 0) begin
				cur_elapsed = (cur_elapsed + 1) & 16'hFFFF;
				// >= so a shortened step ends on the next tick
				if (cur_elapsed >= span) begin
					cur_elapsed = 0;
					cur_step++;
					if (cur_step >= pattern_len(cur_mode, cur_sel)) cur_step = 0;
				end
			end
		end
		r.led_drive    = lit_pattern();
		r.pattern_step = STEP_W'(cur_step);
		expected_leds.push_back(r);
	endtask

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------
	// Output side: random idle per word, plus an optional long stall
	// ------------------------------------------------------------------
	initial begin : result_sink
		int wait_left;
		wait_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) wait_left = rx_burst ? 0 : $urandom_range(0, 9);
			if (rx_hold > 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else if (wait_left > 0) begin
				wait_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_leds.size() == 0) begin
				flag_mismatch("LED word with nothing pending", m_tdata, 0);
			end else begin
				want = expected_leds.pop_front();
				if (m_tdata[LED_W-1:0] != want.led_drive)
					flag_mismatch("led_drive", m_tdata[LED_W-1:0], want.led_drive);
				if (m_tdata[LED_W+STEP_W-1:LED_W] != want.pattern_step)
					flag_mismatch("pattern_step", m_tdata[LED_W+STEP_W-1:LED_W],
						want.pattern_step);
			end
		end
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------
	// Offer one word and return in the step it is accepted. Valid is only
	// dropped when a gap follows, so back-to-back words keep it high.
	task automatic send_word(input logic kind, input logic [MODE_W-1:0] mode,
			input logic [LED_W-1:0] sel);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {2'b00, sel, mode};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		advance_pattern(kind, mode, sel);
	endtask

	task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [LED_W-1:0] sel);
		send_word(KIND_CMD, mode, sel);
	endtask

	// ticks carry random junk in tdata; the block must ignore it
	task automatic send_ticks(input int n);
		for (int i = 0; i < n; i++) begin
			send_word(KIND_TICK, MODE_W'($urandom_range(0, 7)),
				LED_W'($urandom_range(0, 7)));
		end
	endtask

	// Wait until every LED word is back and the pipe is quiet.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_leds.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write all five durations plus one index past the end, which must be
	// dropped. Only done with the block idle.
	task automatic load_durations(input logic [MS_W-1:0] blink_ms, fast_on, fast_off,
			slow_on, slow_off);
		logic [MS_W-1:0] vals [REG_COUNT];
		vals[REG_BLINK_STEP] = blink_ms;
		vals[REG_FAST_ON]    = fast_on;
		vals[REG_FAST_OFF]   = fast_off;
		vals[REG_SLOW_ON]    = slow_on;
		vals[REG_SLOW_OFF]   = slow_off;
		drain();
		for (int r = 0; r <= REG_COUNT; r++) begin
			cfg_we <= 1'b1;
			if (r < REG_COUNT) begin
				cfg_index <= CFG_IDX_W'(r);
				cfg_data  <= vals[r];
			end else begin
				cfg_index <= CFG_IDX_W'($urandom_range(REG_COUNT, IDX_TOP));
				cfg_data  <= MS_W'($urandom);
			end
			@(posedge clk);
			if (r < REG_COUNT) duration_reg[r] = vals[r];
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_random_phase(input int n, input int cmd_pct);
		logic [MODE_W-1:0] m;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < cmd_pct) begin
				// mostly real modes, now and then an undefined code
				m = ($urandom_range(0, 9) == 0)
					? MODE_W'($urandom_range(MODE_RSVD_A, MODE_RSVD_B))
					: MODE_W'($urandom_range(MODE_OFF, MODE_BREATH));
				send_cmd(m, LED_W'($urandom_range(0, 7)));
			end else begin
				send_ticks(1);
			end
		end
	endtask

	function automatic logic [MS_W-1:0] pick_duration(input int flavor);
		case (flavor)
			0: return MS_W'($urandom_range(1, 4));
			1: return MS_W'($urandom_range(1, 30));
			2: begin
				case ($urandom_range(0, 2))
					0: return 16'd1;
					1: return 16'd2;
					default: return 16'hFFFF;
				endcase
			end
			default: return MS_W'($urandom_range(0, 8));   // zero counts as 1 ms
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Out of reset: mode on with all LEDs, held; then the reset durations
	// for fast flash and blink, long enough to see each step boundary, with a short slow-flash run between.
	task automatic test_default_durations();
		send_ticks(2);
		send_cmd(MODE_FAST, 3'b111);
		send_ticks(320);
		send_cmd(MODE_SLOW, 3'b101);
		send_ticks(40);
		send_cmd(MODE_BLINK, 3'b111);
		send_ticks(320);
	endtask

	// Every mode with short steps (blink with three masks), slow on time left at zero.
	task automatic test_every_mode();
		load_durations(16'd2, 16'd1, 16'd2, 16'd0, 16'd3);
		send_cmd(MODE_OFF, 3'b111);
		send_ticks(1);
		send_cmd(MODE_ON, 3'b101);
		send_ticks(1);
		send_cmd(MODE_BLINK, 3'b111);
		send_ticks(4);
		send_cmd(MODE_BLINK, 3'b010);      // single LED: dark step follows
		send_ticks(3);
		send_cmd(MODE_BLINK, 3'b000);      // empty mask: held dark
		send_ticks(2);
		send_cmd(MODE_FAST, 3'b011);
		send_ticks(2);
		send_cmd(MODE_BREATH, 3'b110);     // runs as slow flash
		send_ticks(2);
		send_cmd(MODE_RSVD_A, 3'b001);     // keeps pattern, restarts timer
		send_ticks(1);
		send_cmd(MODE_RSVD_B, 3'b000);
		send_ticks(1);
	endtask

	// Longest steps, then cut the on time below the elapsed count.
	task automatic test_shortened_step();
		load_durations(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_cmd(MODE_FAST, 3'b011);
		send_ticks(6);
		load_durations(RST_BLINK_STEP, 16'd2, 16'd2, RST_SLOW_ON, RST_SLOW_OFF);
		send_ticks(3);
	endtask

	// Sink stalls long while the sender keeps pushing, so s_tready drops.
	task automatic test_backpressure();
		load_durations(16'd3, 16'd2, 16'd1, 16'd4, 16'd2);
		send_cmd(MODE_BLINK, 3'b111);
		rx_hold  = 150;
		tx_burst = 1'b1;
		run_random_phase(40, 10);
		tx_burst = 1'b0;
	endtask

	task automatic test_random_phases();
		int flavor;
		for (int p = 0; p < 5; p++) begin
			flavor = p % 4;
			load_durations(pick_duration(flavor), pick_duration(flavor),
				pick_duration(flavor), pick_duration(flavor), pick_duration(flavor));
			// first phase runs flat out on both sides
			tx_burst = (p == 0) || ($urandom_range(0, 3) == 0);
			rx_burst = (p == 0) || ($urandom_range(0, 3) == 0);
			run_random_phase(100, 12);
		end
		tx_burst = 1'b0;
		rx_burst = 1'b0;
	endtask

	initial begin : stimulus
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= KIND_TICK;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		tx_burst       = 1'b0;
		rx_burst       = 1'b0;
		rx_hold        = 0;
		mismatch_count = 0;

		// reset image of the block
		duration_reg[REG_BLINK_STEP] = RST_BLINK_STEP;
		duration_reg[REG_FAST_ON]    = RST_FAST_ON;
		duration_reg[REG_FAST_OFF]   = RST_FAST_OFF;
		duration_reg[REG_SLOW_ON]    = RST_SLOW_ON;
		duration_reg[REG_SLOW_OFF]   = RST_SLOW_OFF;
		cur_mode    = MODE_ON;
		cur_sel     = 3'b111 & LED_MASK;
		cur_step    = 0;
		cur_elapsed = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_durations();
		test_every_mode();
		test_shortened_step();
		test_backpressure();
		test_random_phases();

		drain();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_leds.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
